@@ sv/adcss_pkg.sv @@
// adcss_pkg: shared types, codes and constants of the ADC scan sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package adcss_pkg;

   localparam int unsigned ListEntries = 8;
   localparam int unsigned ChanWidth = 5;
   localparam logic [3:0] MaxChain = 4'd8;
   localparam logic [7:0] ChanLimit = 8'd31;

   typedef enum logic [1:0] {
      CMD_START_SINGLE = 2'd0,
      CMD_START_CHAIN  = 2'd1,
      CMD_COMPLETE     = 2'd2,
      CMD_UNUSED       = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_BAD_REQ   = 2'd1,
      STS_BUSY      = 2'd2,
      STS_IDLE_DONE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_CHAIN_LENGTH   = 2'd0,
      REG_CHAIN_CHANNELS = 2'd1,
      REG_EIGHT_BIT_MODE = 2'd2,
      REG_NONE           = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SINGLE = 3'b010,
      ST_CHAIN  = 3'b100
   } run_state_type;

   typedef struct packed {
      logic [3:0]  chain_length;
      logic [39:0] chain_channels;
      logic        eight_bit_mode;
   } cfg_type;

   typedef struct packed {
      logic [1:0] status;
      logic       start_conversion;
      logic [4:0] mux_channel;
      logic       result_valid;
      logic [2:0] result_index;
      logic [9:0] result_value;
      logic       done_res;
   } result_type;

   function automatic logic [4:0] list_entry(input logic [39:0] channels,
                                             input logic [2:0] idx);
      logic [4:0] entry;
      entry = '0;
      for (int i = 0; i < ListEntries; i++) begin
         if (idx == i[2:0]) begin
            entry = channels[i*ChanWidth +: ChanWidth];
         end
      end
      return entry;
   endfunction

endpackage

`default_nettype wire

@@ sv/adc_scan_sequencer_core.sv @@
// adc_scan_sequencer_core: top level of the ADC scan sequencer.
// Depends on adcss_pkg, adcss_csr, adcss_step and adcss_out.
//
// Usage:
//   req_* carries one command word (start single, start chain, conversion
//   complete). A word is taken on a rising edge with req_valid high and
//   req_stall low. Every word gives exactly one rsp_* word, taken on an edge
//   with rsp_valid high and rsp_stall low.
//   csr_* writes chain_length (0), chain_channels (1), eight_bit_mode (2)
//   on any edge with csr_we high; write only while no word is in flight.
// Timing:
//   A word is held in the input register, is decided there by the
//   run-state logic, and its response is loaded into the result register
//   when that register can advance; rsp_valid then rises. One word per
//   cycle is sustained while rsp_stall stays low; the single run-state
//   update per word sets that figure.
// Reset (synchronous, active high): sequencer idle, both pipeline registers
//   empty, chain_length 1, chain_channels 0, eight_bit_mode 0.
// Stall: while rsp_stall holds a pending response, the word in the input
//   register waits and req_stall rises; no word is dropped or repeated.
`default_nettype none

module adc_scan_sequencer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output wire logic        req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_channel,
   input  wire logic [9:0]  req_sample,
   output wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   output wire logic [1:0]  rsp_status,
   output wire logic        rsp_start_conversion,
   output wire logic [4:0]  rsp_mux_channel,
   output wire logic        rsp_result_valid,
   output wire logic [2:0]  rsp_result_index,
   output wire logic [9:0]  rsp_result_value,
   output wire logic        rsp_done_res,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [39:0] csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [7:0] channel_ff, channel_in;
   logic [9:0] sample_ff, sample_in;
   logic       advance;
   logic       accept;

   adcss_pkg::cfg_type    cfg;
   adcss_pkg::result_type result;
   adcss_pkg::result_type rsp_word;

   assign advance = !rsp_valid || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      cmd_in = accept ? req_cmd : cmd_ff;
      channel_in = accept ? req_channel : channel_ff;
      sample_in = accept ? req_sample : sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      channel_ff <= channel_in;
      sample_ff <= sample_in;
   end

   adcss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   adcss_step u_step (
      .clock   (clock),
      .reset   (reset),
      .commit  (in_valid_ff && advance),
      .cmd     (cmd_ff),
      .channel (channel_ff),
      .sample  (sample_ff),
      .cfg     (cfg),
      .result  (result)
   );

   adcss_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff),
      .advance    (advance),
      .result     (result),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word)
   );

   assign rsp_status = rsp_word.status;
   assign rsp_start_conversion = rsp_word.start_conversion;
   assign rsp_mux_channel = rsp_word.mux_channel;
   assign rsp_result_valid = rsp_word.result_valid;
   assign rsp_result_index = rsp_word.result_index;
   assign rsp_result_value = rsp_word.result_value;
   assign rsp_done_res = rsp_word.done_res;

endmodule

`default_nettype wire

@@ sv/adcss_csr.sv @@
// adcss_csr: configuration registers of the ADC scan sequencer.
// Depends on adcss_pkg for the register indexes and the cfg_type bundle.
`default_nettype none

module adcss_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [39:0]       csr_wdata,
   output adcss_pkg::cfg_type     cfg
);

   adcss_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (adcss_pkg::reg_index_type'(csr_index))
            adcss_pkg::REG_CHAIN_LENGTH:   cfg_in.chain_length = csr_wdata[3:0];
            adcss_pkg::REG_CHAIN_CHANNELS: cfg_in.chain_channels = csr_wdata;
            adcss_pkg::REG_EIGHT_BIT_MODE: cfg_in.eight_bit_mode = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chain_length <= 4'd1;
         cfg_ff.chain_channels <= '0;
         cfg_ff.eight_bit_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ sv/adcss_step.sv @@
// adcss_step: run-state registers and the per-word decision logic of the sequencer.
// Depends on adcss_pkg; fed by the input register and adcss_csr in the top level.
`default_nettype none

module adcss_step (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              commit,
   input  wire logic [1:0]        cmd,
   input  wire logic [7:0]        channel,
   input  wire logic [9:0]        sample,
   input  wire adcss_pkg::cfg_type cfg,
   output adcss_pkg::result_type  result
);

   adcss_pkg::run_state_type state_ff, state_in;
   logic [3:0] position_ff, position_in;
   logic [3:0] run_length_ff, run_length_in;
   logic [3:0] pos_next;
   logic       len_bad;

   assign pos_next = position_ff + 4'd1;
   assign len_bad = (cfg.chain_length == 4'd0) || (cfg.chain_length > adcss_pkg::MaxChain);

   always_comb begin
      state_in = state_ff;
      position_in = position_ff;
      run_length_in = run_length_ff;
      result = '0;
      result.status = adcss_pkg::STS_OK;
      unique case (adcss_pkg::cmd_type'(cmd))
         adcss_pkg::CMD_START_SINGLE: begin
            if (channel > adcss_pkg::ChanLimit) begin
               result.status = adcss_pkg::STS_BAD_REQ;
            end else if (state_ff != adcss_pkg::ST_IDLE) begin
               result.status = adcss_pkg::STS_BUSY;
            end else begin
               state_in = adcss_pkg::ST_SINGLE;
               position_in = 4'd0;
               result.start_conversion = 1'b1;
               result.mux_channel = channel[4:0];
            end
         end
         adcss_pkg::CMD_START_CHAIN: begin
            if (len_bad) begin
               result.status = adcss_pkg::STS_BAD_REQ;
            end else if (state_ff != adcss_pkg::ST_IDLE) begin
               result.status = adcss_pkg::STS_BUSY;
            end else begin
               state_in = adcss_pkg::ST_CHAIN;
               position_in = 4'd0;
               run_length_in = cfg.chain_length;
               result.start_conversion = 1'b1;
               result.mux_channel = adcss_pkg::list_entry(cfg.chain_channels, 3'd0);
            end
         end
         adcss_pkg::CMD_COMPLETE: begin
            if (state_ff == adcss_pkg::ST_IDLE) begin
               result.status = adcss_pkg::STS_IDLE_DONE;
            end else begin
               result.result_valid = 1'b1;
               result.result_value = cfg.eight_bit_mode ? {2'b00, sample[9:2]} : sample;
               if (state_ff == adcss_pkg::ST_CHAIN) begin
                  result.result_index = position_ff[2:0];
                  position_in = pos_next;
                  if (pos_next >= run_length_ff) begin
                     state_in = adcss_pkg::ST_IDLE;
                     result.done_res = 1'b1;
                  end else begin
                     result.start_conversion = 1'b1;
                     result.mux_channel =
                        adcss_pkg::list_entry(cfg.chain_channels, pos_next[2:0]);
                  end
               end else begin
                  state_in = adcss_pkg::ST_IDLE;
                  result.done_res = 1'b1;
               end
            end
         end
         default: begin
            result.status = adcss_pkg::STS_BAD_REQ;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= adcss_pkg::ST_IDLE;
         position_ff <= 4'd0;
         run_length_ff <= 4'd0;
      end else if (commit) begin
         state_ff <= state_in;
         position_ff <= position_in;
         run_length_ff <= run_length_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/adcss_pkg_dummy_guard.sv @@
// adcss_out: result register of the ADC scan sequencer with its valid flag.
// Depends on adcss_pkg for result_type; driven by adcss_step in the top level.
`default_nettype none

module adcss_out (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load_valid,
   input  wire logic              advance,
   input  wire adcss_pkg::result_type result,
   output wire logic              rsp_valid,
   output adcss_pkg::result_type  rsp_word
);

   logic                  valid_ff, valid_in;
   adcss_pkg::result_type word_ff, word_in;

   always_comb begin
      valid_in = advance ? load_valid : valid_ff;
      word_in = (advance && load_valid) ? result : word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_word = word_ff;

endmodule

`default_nettype wire
